// ----- sv/wtrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted thread range split - shared definitions
// Widths, register codes and the per-stage payload types of the pipeline.
// ----------------------------------------------------------------------------
package wtrs_pkg;

  // field and datapath widths
  localparam int REG_W   = 9;    // config registers, thread counts
  localparam int IDX_W   = 8;    // request index
  localparam int WSUM_W  = 10;   // 2n - i + 1
  localparam int PROD_W  = 18;   // n(n+1), (n-i)t, i(2n-i+1)
  localparam int DIV_W   = 27;   // dividend / partial remainder
  localparam int Q_W     = 9;    // quotient bits, quotient never exceeds t for a valid index
  localparam int DATA_W  = 24;   // output tdata, padded to bytes
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;

  // number of register stages: input, product, dividend, Q_W divide, output
  localparam int NUM_STAGES = Q_W + 4;

  // parameter defaults
  localparam int DEF_MAX_THREADS  = 256;
  localparam int DEF_MAX_REQUESTS = 256;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_THREADS = 2'd1;
  localparam logic [1:0] REG_MIN     = 2'd2;

  // stage 0: operands after saturation
  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [REG_W-1:0]  n;
    logic [REG_W:0]    n_plus1;
    logic [REG_W-1:0]  n_minus_i;
    logic [WSUM_W-1:0] w_sum;
    logic [REG_W-1:0]  t;
    logic [REG_W-1:0]  m;
  } opnd_t;

  // stage 1: first products
  typedef struct packed {
    logic              ok;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] p_dem;
    logic [PROD_W-1:0] p_start;
    logic [REG_W-1:0]  t;
    logic [REG_W-1:0]  m;
  } prod_t;

  // divider stages: two restoring dividers sharing one divisor
  typedef struct packed {
    logic              ok;
    logic [PROD_W-1:0] den;
    logic [REG_W-1:0]  t;
    logic [REG_W-1:0]  m;
    logic [DIV_W-1:0]  rem_dem;
    logic [DIV_W-1:0]  rem_start;
    logic [Q_W-1:0]    q_dem;
    logic [Q_W-1:0]    q_start;
  } div_t;

  // output word
  typedef struct packed {
    logic             ok;
    logic [REG_W-1:0] range_start;
    logic [REG_W-1:0] range_end;
  } res_t;

endpackage

// ----- sv/weighted_thread_range_split_core.sv -----
// ----------------------------------------------------------------------------
// Weighted thread range split core
// Maps a request index to its weighted slice [start, end) of the worker threads.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one request index per
//   word. Output stream (m_tvalid/m_tready/m_tdata/m_tuser) returns one word
//   per request: range start and end in tdata, index_ok in tuser.
//   The APB port sets active requests (0x0), thread count (0x4) and the
//   minimum threads per request (0x8); write only while the block is idle.
// Timing:
//   Fully pipelined, 13 register stages: a request passes the input, product,
//   dividend, divide and output registers in order; one request is taken
//   every cycle unless the pipeline is full and m_tready is low. The depth is
//   set by the two 9-bit restoring dividers, one quotient bit per stage.
// Stall:
//   Each stage holds its word while the stage after it is full and stalled;
//   empty stages keep filling, so up to 13 words queue inside while m_tready
//   is low. Nothing is dropped or repeated.
// Reset:
//   rst (synchronous) empties the pipeline and sets all three configuration registers to 1.
// ----------------------------------------------------------------------------
module weighted_thread_range_split_core #(
  parameter int MAX_THREADS  = wtrs_pkg::DEF_MAX_THREADS,
  parameter int MAX_REQUESTS = wtrs_pkg::DEF_MAX_REQUESTS
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wtrs_pkg::IDX_W-1:0]    s_tdata,   // [7:0] request_index
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wtrs_pkg::DATA_W-1:0]   m_tdata,   // [8:0] range_start,
                                                   // [17:9] range_end, rest 0
  output logic                          m_tuser,   // [0] index_ok
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [wtrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [wtrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int REG_W  = wtrs_pkg::REG_W;
  localparam int Q_W    = wtrs_pkg::Q_W;
  localparam int DIV_W  = wtrs_pkg::DIV_W;
  localparam int NST    = wtrs_pkg::NUM_STAGES;
  localparam int DIV0   = 2;          // stage index of first divider register
  localparam int OUT_ST = NST - 1;

  // configuration registers
  logic [REG_W-1:0] active_requests;
  logic [REG_W-1:0] thread_count;
  logic [REG_W-1:0] min_threads_each;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_requests  <= REG_W'(1);
      thread_count     <= REG_W'(1);
      min_threads_each <= REG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wtrs_pkg::REG_ACTIVE:  active_requests  <= pwdata[REG_W-1:0];
        wtrs_pkg::REG_THREADS: thread_count     <= pwdata[REG_W-1:0];
        wtrs_pkg::REG_MIN:     min_threads_each <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      wtrs_pkg::REG_ACTIVE:  prdata = wtrs_pkg::PDATA_W'(active_requests);
      wtrs_pkg::REG_THREADS: prdata = wtrs_pkg::PDATA_W'(thread_count);
      wtrs_pkg::REG_MIN:     prdata = wtrs_pkg::PDATA_W'(min_threads_each);
      default:               prdata = '0;
    endcase
  end

  // stage valid bits and per-stage load enables (bubbles collapse)
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_in;

  always_comb begin
    en[OUT_ST] = ~vld[OUT_ST] | m_tready;
    for (int k = OUT_ST - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
    vld_in = {vld[NST-2:0], s_tvalid};
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  // stage 0: saturate registers, range check, small operands
  wtrs_pkg::opnd_t op_next, op;
  logic [REG_W-1:0] n_sat, t_sat, i_ext;

  always_comb begin
    n_sat = (32'(active_requests) > MAX_REQUESTS) ? REG_W'(MAX_REQUESTS)
                                                   : active_requests;
    t_sat = (32'(thread_count) > MAX_THREADS) ? REG_W'(MAX_THREADS)
                                               : thread_count;
    i_ext = REG_W'(s_tdata);
    op_next.ok        = i_ext < n_sat;
    op_next.idx       = s_tdata;
    op_next.n         = n_sat;
    op_next.n_plus1   = {1'b0, n_sat} + 1'b1;
    op_next.n_minus_i = n_sat - i_ext;
    op_next.w_sum     = {n_sat, 1'b0} - {1'b0, i_ext} + 1'b1;
    op_next.t         = t_sat;
    op_next.m         = (min_threads_each == '0) ? REG_W'(1) : min_threads_each;
  end

  always_ff @(posedge clk) begin
    if (en[0]) op <= op_next;
  end

  // stage 1: n(n+1), (n-i)t, i(2n-i+1)
  wtrs_pkg::prod_t pr;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pr.ok      <= op.ok;
      pr.den     <= wtrs_pkg::PROD_W'(op.n) * wtrs_pkg::PROD_W'(op.n_plus1);
      pr.p_dem   <= wtrs_pkg::PROD_W'(op.n_minus_i) * wtrs_pkg::PROD_W'(op.t);
      pr.p_start <= wtrs_pkg::PROD_W'(op.idx) * wtrs_pkg::PROD_W'(op.w_sum);
      pr.t       <= op.t;
      pr.m       <= op.m;
    end
  end

  // stage 2: dividends; ceiling via (2p + den - 1), floor via p*t
  wtrs_pkg::div_t dv [0:Q_W];

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      dv[0].ok        <= pr.ok;
      dv[0].den       <= pr.den;
      dv[0].t         <= pr.t;
      dv[0].m         <= pr.m;
      dv[0].rem_dem   <= DIV_W'({pr.p_dem, 1'b0}) + DIV_W'(pr.den) - DIV_W'(1);
      dv[0].rem_start <= DIV_W'(pr.p_start) * DIV_W'(pr.t);
      dv[0].q_dem     <= '0;
      dv[0].q_start   <= '0;
    end
  end

  // divider stages: one quotient bit per stage, MSB first
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    localparam int SH = Q_W - k;
    wtrs_pkg::div_t d_next;
    logic [DIV_W-1:0] trial;
    logic ge_dem, ge_start;

    always_comb begin
      trial    = DIV_W'(dv[k-1].den) << SH;
      ge_dem   = dv[k-1].rem_dem >= trial;
      ge_start = dv[k-1].rem_start >= trial;
      d_next           = dv[k-1];
      d_next.rem_dem   = ge_dem ? dv[k-1].rem_dem - trial : dv[k-1].rem_dem;
      d_next.rem_start = ge_start ? dv[k-1].rem_start - trial
                                  : dv[k-1].rem_start;
      d_next.q_dem     = {dv[k-1].q_dem[Q_W-2:0], ge_dem};
      d_next.q_start   = {dv[k-1].q_start[Q_W-2:0], ge_start};
    end

    always_ff @(posedge clk) begin
      if (en[DIV0+k]) dv[k] <= d_next;
    end
  end

  // output stage: apply minimum, cap end at t, pull start down
  wtrs_pkg::res_t res_next, res;
  logic [REG_W-1:0] demand, end_v, diff;
  logic [REG_W:0]   sum;

  always_comb begin
    demand = (dv[Q_W].q_dem < dv[Q_W].m) ? dv[Q_W].m : dv[Q_W].q_dem;
    sum    = {1'b0, dv[Q_W].q_start} + {1'b0, demand};
    end_v  = (sum > {1'b0, dv[Q_W].t}) ? dv[Q_W].t : sum[REG_W-1:0];
    diff   = end_v - demand;
    res_next.ok = dv[Q_W].ok;
    if (!dv[Q_W].ok) begin
      res_next.range_start = '0;
      res_next.range_end   = '0;
    end else begin
      res_next.range_end = end_v;
      if (end_v >= demand) begin
        res_next.range_start = (diff < dv[Q_W].q_start) ? diff : dv[Q_W].q_start;
      end else begin
        res_next.range_start = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) res <= res_next;
  end

  assign m_tvalid = vld[OUT_ST];
  assign m_tdata  = wtrs_pkg::DATA_W'({res.range_end, res.range_start});
  assign m_tuser  = res.ok;

endmodule
